@@ rtl/core/ft12_pkg.sv @@
// ----------------------------------------------------------------------------
// ft12_pkg
// Shared constants and types for the FT1.2 frame deframer.
// ----------------------------------------------------------------------------
package ft12_pkg;

   localparam logic [7:0] BYTE_ACK   = 8'hE5;
   localparam logic [7:0] BYTE_FIXED = 8'h10;
   localparam logic [7:0] BYTE_END   = 8'h16;
   localparam logic [7:0] BYTE_VAR   = 8'h68;
   localparam logic [8:0] VAR_EXTRA  = 9'd6;
   localparam logic [8:0] FIXED_LEN  = 9'd6;
   localparam logic [8:0] ACK_LEN    = 9'd1;

   localparam logic [1:0] KIND_NONE  = 2'd0;
   localparam logic [1:0] KIND_ACK   = 2'd1;
   localparam logic [1:0] KIND_FIXED = 2'd2;
   localparam logic [1:0] KIND_VAR   = 2'd3;

   localparam logic [2:0] ST_HUNT   = 3'd0;
   localparam logic [2:0] ST_IN     = 3'd1;
   localparam logic [2:0] ST_OK     = 3'd2;
   localparam logic [2:0] ST_CSERR  = 3'd3;
   localparam logic [2:0] ST_LENERR = 3'd4;

   typedef enum logic {
      PH_HUNT  = 1'b0,
      PH_FRAME = 1'b1
   } phase_type;

   typedef struct packed {
      logic [7:0] echo_byte;
      logic [1:0] frame_kind;
      logic [8:0] byte_index;
      logic       frame_start;
      logic       frame_last;
      logic [2:0] status;
      logic [8:0] frame_length;
   } result_type;

endpackage

@@ rtl/core/ft12_if.sv @@
// ----------------------------------------------------------------------------
// ft12 channel interfaces
// Valid/ready channels for received bytes and for annotated result items.
// ----------------------------------------------------------------------------
interface ft12_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ft12_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] echo_byte;
   logic [1:0] frame_kind;
   logic [8:0] byte_index;
   logic       frame_start;
   logic       frame_last;
   logic [2:0] status;
   logic [8:0] frame_length;

   modport source (output valid, output echo_byte, output frame_kind, output byte_index,
                   output frame_start, output frame_last, output status,
                   output frame_length, input ready);
   modport sink   (input valid, input echo_byte, input frame_kind, input byte_index,
                   input frame_start, input frame_last, input status,
                   input frame_length, output ready);
endinterface

@@ rtl/core/ft12_parse.sv @@
// ----------------------------------------------------------------------------
// ft12_parse
// Frame state machine: hunt state, position, length and running sum.
// ----------------------------------------------------------------------------
module ft12_parse (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [7:0]            rx_byte,
   output ft12_pkg::result_type  result
);

   ft12_pkg::phase_type phase_ff, phase_in;
   logic [1:0] kind_ff, kind_in;
   logic [8:0] pos_ff, pos_in;
   logic [7:0] len_ff, len_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] sum_add;
   logic [8:0] var_len;
   logic [8:0] user_end;
   logic       add_byte;

   assign sum_add  = sum_ff + rx_byte;
   assign var_len  = {1'b0, len_ff} + ft12_pkg::VAR_EXTRA;
   assign user_end = {1'b0, len_ff} + 9'd4;

   // result for the byte at the input
   always_comb begin
      result              = '0;
      result.echo_byte    = rx_byte;
      add_byte            = 1'b0;
      unique case (phase_ff)
         ft12_pkg::PH_HUNT: begin
            result.status = ft12_pkg::ST_HUNT;
            priority if (rx_byte == ft12_pkg::BYTE_ACK) begin
               result.frame_kind   = ft12_pkg::KIND_ACK;
               result.frame_start  = 1'b1;
               result.frame_last   = 1'b1;
               result.status       = ft12_pkg::ST_OK;
               result.frame_length = ft12_pkg::ACK_LEN;
            end else if (rx_byte == ft12_pkg::BYTE_FIXED) begin
               result.frame_kind   = ft12_pkg::KIND_FIXED;
               result.frame_start  = 1'b1;
               result.status       = ft12_pkg::ST_IN;
               result.frame_length = ft12_pkg::FIXED_LEN;
            end else if (rx_byte == ft12_pkg::BYTE_VAR) begin
               result.frame_kind   = ft12_pkg::KIND_VAR;
               result.frame_start  = 1'b1;
               result.status       = ft12_pkg::ST_IN;
            end else begin
               result.frame_kind   = ft12_pkg::KIND_NONE;
            end
         end
         ft12_pkg::PH_FRAME: begin
            result.frame_kind = kind_ff;
            result.byte_index = pos_ff;
            result.status     = ft12_pkg::ST_IN;
            if (kind_ff == ft12_pkg::KIND_FIXED) begin
               result.frame_length = ft12_pkg::FIXED_LEN;
               priority if (pos_ff <= 9'd3) begin
                  add_byte = 1'b1;
               end else if (pos_ff == 9'd4) begin
                  if (rx_byte != sum_ff) begin
                     result.status     = ft12_pkg::ST_CSERR;
                     result.frame_last = 1'b1;
                  end
               end else begin
                  result.status     = (rx_byte == ft12_pkg::BYTE_END) ?
                                      ft12_pkg::ST_OK : ft12_pkg::ST_CSERR;
                  result.frame_last = 1'b1;
               end
            end else begin
               priority if (pos_ff == 9'd1) begin
                  result.frame_length = '0;
               end else if (pos_ff == 9'd2) begin
                  if (rx_byte != len_ff) begin
                     result.status     = ft12_pkg::ST_LENERR;
                     result.frame_last = 1'b1;
                  end else begin
                     result.frame_length = var_len;
                  end
               end else begin
                  result.frame_length = var_len;
                  priority if (pos_ff == 9'd3) begin
                     if (rx_byte != ft12_pkg::BYTE_VAR) begin
                        result.status     = ft12_pkg::ST_CSERR;
                        result.frame_last = 1'b1;
                     end
                  end else if (pos_ff < user_end) begin
                     add_byte = 1'b1;
                  end else if (pos_ff == user_end) begin
                     if (rx_byte != sum_ff) begin
                        result.status     = ft12_pkg::ST_CSERR;
                        result.frame_last = 1'b1;
                     end
                  end else begin
                     result.status     = ft12_pkg::ST_OK;
                     result.frame_last = 1'b1;
                  end
               end
            end
         end
         default: begin
            result.status = ft12_pkg::ST_HUNT;
         end
      endcase
   end

   // next state
   always_comb begin
      phase_in = phase_ff;
      kind_in  = kind_ff;
      pos_in   = pos_ff;
      len_in   = len_ff;
      sum_in   = sum_ff;
      unique case (phase_ff)
         ft12_pkg::PH_HUNT: begin
            if (result.frame_start && !result.frame_last) begin
               phase_in = ft12_pkg::PH_FRAME;
               kind_in  = result.frame_kind;
               pos_in   = 9'd1;
               len_in   = '0;
               sum_in   = '0;
            end
         end
         ft12_pkg::PH_FRAME: begin
            if (result.frame_last) begin
               phase_in = ft12_pkg::PH_HUNT;
               kind_in  = ft12_pkg::KIND_NONE;
               pos_in   = '0;
               len_in   = '0;
               sum_in   = '0;
            end else begin
               pos_in = pos_ff + 9'd1;
               if (add_byte) begin
                  sum_in = sum_add;
               end
               if (kind_ff == ft12_pkg::KIND_VAR && pos_ff == 9'd1) begin
                  len_in = rx_byte;
               end
            end
         end
         default: begin
            phase_in = ft12_pkg::PH_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ft12_pkg::PH_HUNT;
         kind_ff  <= ft12_pkg::KIND_NONE;
         pos_ff   <= '0;
         len_ff   <= '0;
         sum_ff   <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         kind_ff  <= kind_in;
         pos_ff   <= pos_in;
         len_ff   <= len_in;
         sum_ff   <= sum_in;
      end
   end

   a_hunt_clean: assert property (@(posedge clock) disable iff (reset)
      phase_ff == ft12_pkg::PH_HUNT |-> pos_ff == 9'd0 && sum_ff == 8'd0)
      else $error("hunt state with stale position or sum");

   a_frame_kind: assert property (@(posedge clock) disable iff (reset)
      phase_ff == ft12_pkg::PH_FRAME |->
         (kind_ff == ft12_pkg::KIND_FIXED || kind_ff == ft12_pkg::KIND_VAR))
      else $error("in frame without a multi-byte kind");

   a_last_hunt: assert property (@(posedge clock) disable iff (reset)
      step && result.frame_last |=> phase_ff == ft12_pkg::PH_HUNT)
      else $error("frame closed but parser did not return to hunt");

   a_last_status: assert property (@(posedge clock) disable iff (reset)
      result.frame_last |-> (result.status == ft12_pkg::ST_OK ||
         result.status == ft12_pkg::ST_CSERR || result.status == ft12_pkg::ST_LENERR))
      else $error("closing byte without a final status");

endmodule

@@ rtl/core/ft12_out_reg.sv @@
// ----------------------------------------------------------------------------
// ft12_out_reg
// Result register driving the response channel.
// ----------------------------------------------------------------------------
module ft12_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  ft12_pkg::result_type  result,
   output logic                  can_load,
   ft12_rsp_if.source            rsp_chan
);

   logic                 valid_ff, valid_in;
   ft12_pkg::result_type data_ff;

   assign can_load = !valid_ff || rsp_chan.ready;
   assign valid_in = load || (valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_chan.valid        = valid_ff;
   assign rsp_chan.echo_byte    = data_ff.echo_byte;
   assign rsp_chan.frame_kind   = data_ff.frame_kind;
   assign rsp_chan.byte_index   = data_ff.byte_index;
   assign rsp_chan.frame_start  = data_ff.frame_start;
   assign rsp_chan.frame_last   = data_ff.frame_last;
   assign rsp_chan.status       = data_ff.status;
   assign rsp_chan.frame_length = data_ff.frame_length;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> can_load)
      else $error("result register loaded while holding an untaken item");

endmodule

@@ rtl/core/ft12_frame_deframer.sv @@
// ----------------------------------------------------------------------------
// ft12_frame_deframer
// FT1.2 frame recognizer: annotates each received byte with frame kind,
// index, status and frame length.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake         | payload
//  req_chan  | in  | valid/ready       | rx_byte[7:0]
//  rsp_chan  | out | valid/ready       | echo_byte, frame_kind, byte_index, frame_start,
//            |     |                   | frame_last, status, frame_length
//
//  One byte per cycle unless the receiver stalls; input register, then result register.
//  The frame state advances only when a byte moves from the input register to the
//  result register, so stalls on the response side hold the parser in place.
//  Synchronous reset returns the parser to hunting and empties both registers.
// ----------------------------------------------------------------------------
module ft12_frame_deframer (
   input  logic       clock,
   input  logic       reset,
   ft12_req_if.sink   req_chan,
   ft12_rsp_if.source rsp_chan
);

   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_byte_ff;
   logic                 advance;
   logic                 can_load;
   logic                 take;
   ft12_pkg::result_type result;

   assign advance        = in_valid_ff && can_load;
   assign req_chan.ready = !in_valid_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;
   assign in_valid_in    = take || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_byte_ff <= req_chan.rx_byte;
      end
   end

   ft12_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (in_byte_ff),
      .result  (result)
   );

   ft12_out_reg u_out (
      .clock    (clock),
      .reset    (reset),
      .load     (advance),
      .result   (result),
      .can_load (can_load),
      .rsp_chan (rsp_chan)
   );

   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff))
      else $error("stalled byte lost from input register");

   a_advance_out: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_chan.valid)
      else $error("advanced byte did not reach the result register");

endmodule

@@ tb/ft12_tb_pkg.sv @@
// ----------------------------------------------------------------------------
// ft12_tb_pkg
// Scoreboard for the FT1.2 deframer bench: tracks the frame state from the
// accepted bytes, predicts each annotated item and checks the block's output.
// ----------------------------------------------------------------------------
package ft12_tb_pkg;
   import ft12_pkg::*;

   class frame_annotation_board;
      phase_type  hunt_phase;
      logic [1:0] frame_kind;
      logic [8:0] frame_pos;
      logic [7:0] first_len;
      logic [7:0] byte_sum;

      result_type pending_annotations[$];
      int errors;
      int bytes_seen;
      int acks_seen;
      int frames_ok;
      int checksum_fails;
      int length_fails;

      function new();
         errors = 0;
         bytes_seen = 0;
         acks_seen = 0;
         frames_ok = 0;
         checksum_fails = 0;
         length_fails = 0;
         pending_annotations.delete();
         resync();
      endfunction

      function void resync();
         hunt_phase = PH_HUNT;
         frame_kind = KIND_NONE;
         frame_pos = '0;
         first_len = '0;
         byte_sum = '0;
      endfunction

      function int waiting();
         return pending_annotations.size();
      endfunction

      // Predict the annotation of one accepted byte and queue it.
      function void note_byte(logic [7:0] b);
         result_type r;
         logic [8:0] len9;
         r = '0;
         r.echo_byte = b;
         r.frame_kind = KIND_NONE;
         r.status = ST_HUNT;
         len9 = {1'b0, first_len};
         if (hunt_phase == PH_HUNT) begin
            if (b == BYTE_ACK) begin
               r.frame_kind = KIND_ACK;
               r.frame_start = 1'b1;
               r.frame_last = 1'b1;
               r.status = ST_OK;
               r.frame_length = ACK_LEN;
            end else if (b == BYTE_FIXED || b == BYTE_VAR) begin
               r.frame_kind = (b == BYTE_FIXED) ? KIND_FIXED : KIND_VAR;
               r.frame_start = 1'b1;
               r.status = ST_IN;
               r.frame_length = (b == BYTE_FIXED) ? FIXED_LEN : 9'd0;
               hunt_phase = PH_FRAME;
               frame_kind = r.frame_kind;
               frame_pos = 9'd1;
               byte_sum = '0;
               first_len = '0;
            end
         end else begin
            r.frame_kind = frame_kind;
            r.byte_index = frame_pos;
            r.status = ST_IN;
            if (frame_kind == KIND_FIXED) begin
               r.frame_length = FIXED_LEN;
               if (frame_pos <= 9'd3) begin
                  byte_sum = byte_sum + b;
               end else if (frame_pos == 9'd4) begin
                  if (b != byte_sum) begin
                     r.status = ST_CSERR;
                     r.frame_last = 1'b1;
                  end
               end else begin
                  r.status = (b == BYTE_END) ? ST_OK : ST_CSERR;
                  r.frame_last = 1'b1;
               end
            end else begin
               if (frame_pos == 9'd1) begin
                  first_len = b;
               end else if (frame_pos == 9'd2) begin
                  if (b != first_len) begin
                     r.status = ST_LENERR;
                     r.frame_last = 1'b1;
                  end else begin
                     r.frame_length = len9 + VAR_EXTRA;
                  end
               end else begin
                  r.frame_length = len9 + VAR_EXTRA;
                  if (frame_pos == 9'd3) begin
                     // second start byte must repeat 0x68
                     if (b != BYTE_VAR) begin
                        r.status = ST_CSERR;
                        r.frame_last = 1'b1;
                     end
                  end else if (frame_pos < len9 + 9'd4) begin
                     byte_sum = byte_sum + b;
                  end else if (frame_pos == len9 + 9'd4) begin
                     if (b != byte_sum) begin
                        r.status = ST_CSERR;
                        r.frame_last = 1'b1;
                     end
                  end else begin
                     // end byte is not checked
                     r.status = ST_OK;
                     r.frame_last = 1'b1;
                  end
               end
            end
            if (r.frame_last) resync();
            else frame_pos = frame_pos + 9'd1;
         end

         bytes_seen++;
         if (r.frame_last) begin
            case (r.status)
               ST_OK:     if (r.frame_kind == KIND_ACK) acks_seen++; else frames_ok++;
               ST_CSERR:  checksum_fails++;
               ST_LENERR: length_fails++;
               default:   ;
            endcase
         end
         pending_annotations.push_back(r);
      endfunction

      function void compare(string field, int unsigned want, int unsigned got,
                            longint stamp);
         if (want != got) begin
            $display("%0t ns: mismatch on %s: expected %0d, actual %0d",
                     stamp, field, want, got);
            errors++;
         end
      endfunction

      function void check_annotation(result_type got, longint stamp);
         result_type want;
         if (pending_annotations.size() == 0) begin
            $display("%0t ns: unexpected item, actual byte %0d (nothing expected)",
                     stamp, got.echo_byte);
            errors++;
            return;
         end
         want = pending_annotations.pop_front();
         compare("echo_byte",    want.echo_byte,    got.echo_byte,    stamp);
         compare("frame_kind",   want.frame_kind,   got.frame_kind,   stamp);
         compare("byte_index",   want.byte_index,   got.byte_index,   stamp);
         compare("frame_start",  want.frame_start,  got.frame_start,  stamp);
         compare("frame_last",   want.frame_last,   got.frame_last,   stamp);
         compare("status",       want.status,       got.status,       stamp);
         compare("frame_length", want.frame_length, got.frame_length, stamp);
      endfunction
   endclass

endpackage

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Bench for ft12_frame_deframer: feeds acks, fixed and variable frames (good,
// bad checksum, bad end, length mismatch, broken second start) and line noise
// through bursty traffic against a stalling receiver, and checks every item.
// ----------------------------------------------------------------------------
module tb_top;
   import ft12_pkg::*;
   import ft12_tb_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_BYTES = 500;
   localparam int HOLD_AFTER   = 200;
   localparam int HOLD_CYCLES  = 150;
   localparam int DRAIN_CYCLES = 10;

   typedef enum int {
      FLAW_NONE,
      FLAW_CHECKSUM,
      FLAW_END,
      FLAW_LENGTH,
      FLAW_START2
   } flaw_type;

   logic clock = 1'b0;
   logic reset;

   ft12_req_if req_bus();
   ft12_rsp_if rsp_bus();

   ft12_frame_deframer dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   frame_annotation_board board = new();

   int cycles = 0;
   int burst_left = 0;
   int results_seen = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   int rx_cycle = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("TEST FAILED");
         $finish;
      end
   end

   // receiver: check accepted items, then pick next ready
   always @(posedge clock) begin
      result_type got;
      logic next_ready;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.echo_byte    = rsp_bus.echo_byte;
         got.frame_kind   = rsp_bus.frame_kind;
         got.byte_index   = rsp_bus.byte_index;
         got.frame_start  = rsp_bus.frame_start;
         got.frame_last   = rsp_bus.frame_last;
         got.status       = rsp_bus.status;
         got.frame_length = rsp_bus.frame_length;
         board.check_annotation(got, $time);
         results_seen++;
      end
      rx_cycle++;
      if (hold_left > 0) begin
         hold_left--;
         next_ready = 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
         // long hold-off: the block fills up and must stall its input
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         next_ready = 1'b0;
      end else begin
         case ((rx_cycle / 48) % 4)
            0: next_ready = 1'b1;
            1: next_ready = ($urandom_range(0, 3) != 0);
            2: next_ready = 1'($urandom_range(0, 1));
            default: next_ready = ((rx_cycle % 5) < 2);
         endcase
      end
      rsp_bus.ready <= next_ready;
   end

   function automatic logic [7:0] nonzero();
      return 8'($urandom_range(1, 255));
   endfunction

   // drives one byte, honoring the burst/gap pattern, and waits for acceptance
   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_bus.valid <= 1'b1;
      req_bus.rx_byte <= b;
      do @(posedge clock); while (!req_bus.ready);
      board.note_byte(b);
   endtask

   task automatic send_fixed(input logic [7:0] ctrl, input logic [7:0] addr_lo,
                             input logic [7:0] addr_hi, input flaw_type flaw);
      logic [7:0] sum;
      sum = ctrl + addr_lo + addr_hi;
      send_byte(BYTE_FIXED);
      send_byte(ctrl);
      send_byte(addr_lo);
      send_byte(addr_hi);
      send_byte(flaw == FLAW_CHECKSUM ? sum + nonzero() : sum);
      if (flaw == FLAW_CHECKSUM) return;
      send_byte(flaw == FLAW_END ? BYTE_END ^ nonzero() : BYTE_END);
   endtask

   task automatic send_variable(input logic [7:0] len, input flaw_type flaw);
      logic [7:0] sum;
      logic [7:0] len2;
      logic [7:0] body;
      sum = '0;
      len2 = (flaw == FLAW_LENGTH) ? len + nonzero() : len;
      send_byte(BYTE_VAR);
      send_byte(len);
      send_byte(len2);
      if (flaw == FLAW_LENGTH) return;
      send_byte(flaw == FLAW_START2 ? BYTE_VAR ^ nonzero() : BYTE_VAR);
      if (flaw == FLAW_START2) return;
      for (int i = 0; i < int'(len); i++) begin
         body = 8'($urandom);
         sum = sum + body;
         send_byte(body);
      end
      send_byte(flaw == FLAW_CHECKSUM ? sum + nonzero() : sum);
      if (flaw == FLAW_CHECKSUM) return;
      send_byte(flaw == FLAW_END ? BYTE_END ^ nonzero() : BYTE_END);
   endtask

   // line noise that cannot open a frame
   function automatic logic [7:0] quiet_byte();
      logic [7:0] b;
      b = 8'($urandom);
      while (b == BYTE_ACK || b == BYTE_FIXED || b == BYTE_VAR) b = 8'($urandom);
      return b;
   endfunction

   function automatic logic [7:0] short_len();
      return 8'($urandom_range(0, 16));
   endfunction

   initial begin
      int pick;
      int start_count;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.rx_byte = '0;
      rsp_bus.ready = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: noise extremes, ack, each frame outcome
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(BYTE_ACK);
      send_fixed(8'hFF, 8'h00, 8'hFF, FLAW_NONE);
      send_fixed(8'h00, 8'h00, 8'h00, FLAW_CHECKSUM);
      send_fixed(8'h53, 8'h01, 8'h00, FLAW_END);
      send_variable(8'd0, FLAW_NONE);
      send_variable(8'd4, FLAW_LENGTH);
      send_variable(8'd2, FLAW_START2);
      send_variable(8'd1, FLAW_CHECKSUM);
      send_variable(8'd2, FLAW_END);

      // random: mostly well-formed frames with random content
      start_count = board.bytes_seen;
      send_variable(8'd255, FLAW_NONE);
      while (board.bytes_seen - start_count < RANDOM_BYTES) begin
         pick = $urandom_range(0, 99);
         if (pick < 30)
            send_fixed(8'($urandom), 8'($urandom), 8'($urandom), FLAW_NONE);
         else if (pick < 37)
            send_fixed(8'($urandom), 8'($urandom), 8'($urandom), FLAW_CHECKSUM);
         else if (pick < 42)
            send_fixed(8'($urandom), 8'($urandom), 8'($urandom), FLAW_END);
         else if (pick < 70)
            send_variable(short_len(), FLAW_NONE);
         else if (pick < 72)
            send_variable(8'($urandom_range(100, 140)), FLAW_NONE);
         else if (pick < 78)
            send_variable(short_len(), FLAW_CHECKSUM);
         else if (pick < 82)
            send_variable(8'($urandom), FLAW_LENGTH);
         else if (pick < 85)
            send_variable(short_len(), FLAW_START2);
         else if (pick < 88)
            send_variable(short_len(), FLAW_END);
         else if (pick < 93)
            send_byte(BYTE_ACK);
         else if (pick < 99)
            send_byte(quiet_byte());
         else
            send_byte(8'($urandom));
      end
      req_bus.valid <= 1'b0;

      while (board.waiting() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d bytes: %0d good frames, %0d acks,", board.bytes_seen,
               board.frames_ok, board.acks_seen);
      $display("  %0d checksum/end/start failures, %0d length mismatches, one long stall",
               board.checksum_fails, board.length_fails);
      if (board.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/ft12_pkg.sv
rtl/core/ft12_if.sv
rtl/core/ft12_parse.sv
rtl/core/ft12_out_reg.sv
rtl/core/ft12_frame_deframer.sv
tb/ft12_tb_pkg.sv
tb/tb_top.sv
